>>> design/tdpt_pkg.sv
// Shared definitions for the trial-division prime test.
// Holds the default value width, divisor constants and the sequencer state type.
// No dependencies.
package tdpt_pkg;

  localparam int VALUE_WIDTH_DEF = 32;

  // Smallest prime, and the first odd divisor that is tried.
  localparam int SMALLEST_PRIME = 2;
  localparam int FIRST_DIVISOR  = 3;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_NORM  = 4'b0010,
    ST_CHECK = 4'b0100,
    ST_DIV   = 4'b1000
  } state_t;

endpackage

>>> design/trial_division_prime_test.sv
// Trial-division prime test: top level with sequencer and divisor bookkeeping.
// Depends on tdpt_pkg and tdpt_rem_step.
//
// Usage:
//   Input channel in_valid/in_stall/in_number carries one signed value per
//   transfer. Result channel out_valid/out_stall/out_is_prime returns exactly
//   one bit per input, in order. A transfer happens when valid is high and
//   stall is low.
//   Negative values, 0, 1 and even values are answered straight from the
//   input transfer: result valid on the next cycle. Odd values of 3 and up
//   run the iterative test, one item at a time; in_stall stays high until
//   the answer is loaded into the output register.
//   For odd values the sequencer first left-aligns the value, then for each
//   odd divisor d tried runs one bound check and then the bit-serial
//   remainder unit over the dividend bits not yet taken into the prefix.
//   That unit sets the rate: a 32-bit prime near 2^31 tries about 23,000
//   divisors.
//   The divisor square is kept by an add (d+2)^2 = d^2 + 4d + 4, and the
//   leading remainder bits are carried over from divisor to divisor.
//   A stalled result holds in the output register; the input side is taken
//   again as soon as that register is free or drains in the same cycle.
//   Reset (rst_n low, synchronous) returns the sequencer to idle and drops
//   any pending result.
module trial_division_prime_test
  import tdpt_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [VALUE_WIDTH-1:0] in_number,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_is_prime
);

  localparam int W  = VALUE_WIDTH;
  localparam int DW = W / 2 + 1;        // divisor and remainder width
  localparam int PW = DW + 1;           // next power of two above divisor
  localparam int SW = W + 1;            // divisor square
  localparam int CW = $clog2(W + 1);    // bit counts

  state_t        state_r, state_nxt;
  logic [W-1:0]  n_r, n_nxt;             // value under test
  logic [W-1:0]  sh_r, sh_nxt;           // left-aligned value / dividend bits left
  logic [W-1:0]  base_sh_r, base_sh_nxt; // dividend bits below the preloaded prefix
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] base_rem_r, base_rem_nxt; // prefix of the value shorter than d
  logic [DW-1:0] d_r, d_nxt;
  logic [SW-1:0] sq_r, sq_nxt;
  logic [PW-1:0] pow_r, pow_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] base_cnt_r, base_cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_is_prime_r, out_is_prime_nxt;

  logic          out_free;
  logic          in_xfer;
  logic          direct;
  logic [DW-1:0] step_rem;
  logic [DW-1:0] d_plus2;

  tdpt_rem_step #(.DW(DW)) u_rem_step (
    .rem_in  (rem_r),
    .bit_in  (sh_r[W-1]),
    .divisor (d_r),
    .rem_out (step_rem)
  );

  // Output register is free if empty or drained this cycle
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE) || !out_free;
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid    = out_valid_r;
  assign out_is_prime = out_is_prime_r;

  // Negative, zero, one or even: answer without the divisor loop
  assign direct  = in_number[W-1] || !in_number[0] || (in_number == W'(1));
  assign d_plus2 = d_r + DW'(SMALLEST_PRIME);

  always_comb begin
    state_nxt        = state_r;
    n_nxt            = n_r;
    sh_nxt           = sh_r;
    base_sh_nxt      = base_sh_r;
    rem_nxt          = rem_r;
    base_rem_nxt     = base_rem_r;
    d_nxt            = d_r;
    sq_nxt           = sq_r;
    pow_nxt          = pow_r;
    cnt_nxt          = cnt_r;
    base_cnt_nxt     = base_cnt_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_is_prime_nxt = out_is_prime_r;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (direct) begin
            out_valid_nxt    = 1'b1;
            out_is_prime_nxt = (in_number == W'(SMALLEST_PRIME));
          end else begin
            n_nxt     = in_number;
            sh_nxt    = in_number;
            cnt_nxt   = CW'(W);
            state_nxt = ST_NORM;
          end
        end
      end

      ST_NORM: begin
        // Left-align the value; cnt ends at its bit length
        if (sh_r[W-1]) begin
          d_nxt        = DW'(FIRST_DIVISOR);
          sq_nxt       = SW'(FIRST_DIVISOR * FIRST_DIVISOR);
          pow_nxt      = PW'(4);
          base_rem_nxt = DW'(1);
          base_sh_nxt  = sh_r << 1;
          base_cnt_nxt = cnt_r - CW'(1);
          state_nxt    = ST_CHECK;
        end else begin
          sh_nxt  = sh_r << 1;
          cnt_nxt = cnt_r - CW'(1);
        end
      end

      ST_CHECK: begin
        if (sq_r > {1'b0, n_r}) begin
          // no divisor up to the square root: prime
          if (out_free) begin
            out_valid_nxt    = 1'b1;
            out_is_prime_nxt = 1'b1;
            state_nxt        = ST_IDLE;
          end
        end else begin
          rem_nxt   = base_rem_r;
          sh_nxt    = base_sh_r;
          cnt_nxt   = base_cnt_r;
          state_nxt = ST_DIV;
        end
      end

      ST_DIV: begin
        if (cnt_r == '0) begin
          if (rem_r == '0) begin
            if (out_free) begin
              out_valid_nxt    = 1'b1;
              out_is_prime_nxt = 1'b0;
              state_nxt        = ST_IDLE;
            end
          end else begin
            // next odd divisor; square by increment
            d_nxt  = d_plus2;
            sq_nxt = sq_r + SW'({d_r, 2'b00}) + SW'(4);
            if ({1'b0, d_plus2} >= pow_r) begin
              // divisor gains a bit: prefix takes one more dividend bit
              pow_nxt      = pow_r << 1;
              base_rem_nxt = {base_rem_r[DW-2:0], base_sh_r[W-1]};
              base_sh_nxt  = base_sh_r << 1;
              base_cnt_nxt = base_cnt_r - CW'(1);
            end
            state_nxt = ST_CHECK;
          end
        end else begin
          rem_nxt = step_rem;
          sh_nxt  = sh_r << 1;
          cnt_nxt = cnt_r - CW'(1);
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r            <= n_nxt;
    sh_r           <= sh_nxt;
    base_sh_r      <= base_sh_nxt;
    rem_r          <= rem_nxt;
    base_rem_r     <= base_rem_nxt;
    d_r            <= d_nxt;
    sq_r           <= sq_nxt;
    pow_r          <= pow_nxt;
    cnt_r          <= cnt_nxt;
    base_cnt_r     <= base_cnt_nxt;
    out_is_prime_r <= out_is_prime_nxt;
  end

  // Partial remainder always below the divisor
  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < d_r))
    else $error("remainder not below divisor");

  // Only odd divisors are tried
  a_div_odd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHECK || state_r == ST_DIV) |-> d_r[0])
    else $error("even divisor");

  // Incremental square tracks the divisor
  a_square: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHECK) |-> (sq_r == (SW'(d_r) * SW'(d_r))))
    else $error("divisor square out of step");

  // Divisor stays below its power-of-two bound
  a_pow_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> ({1'b0, d_r} < pow_r) && ({d_r, 1'b0} >= pow_r))
    else $error("divisor length tracking lost");

endmodule

>>> design/tdpt_rem_step.sv
// One restoring-division step: shift in one dividend bit, subtract divisor if it fits.
// Remainder unit of the prime test sequencer. Depends on nothing.
module tdpt_rem_step #(
  parameter int DW = 17
) (
  input  logic [DW-1:0] rem_in,
  input  logic          bit_in,
  input  logic [DW-1:0] divisor,
  output logic [DW-1:0] rem_out
);

  logic [DW:0] trial;
  logic [DW:0] diff;
  logic        fits;

  assign trial = {rem_in, bit_in};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = trial >= {1'b0, divisor};

  // rem_in < divisor, so either branch is below divisor and fits DW bits
  assign rem_out = fits ? diff[DW-1:0] : trial[DW-1:0];

endmodule

>>> sim/testbench.sv
// Self-checking bench for trial_division_prime_test: random and directed values
// with bursty idling on both channels. Depends on tdpt_pkg and the design files.
module testbench;
  import tdpt_pkg::*;

  localparam int VW = VALUE_WIDTH_DEF;
  // Longest quiet stretch allowed. A prime just below 2^31 keeps the block busy
  // through its whole search with no transfer on either side, well inside this limit.
  localparam int unsigned QUIET_LIMIT = 2_000_000;
  // Random odd values above 16 bits are kept to ones that fall to a small factor,
  // so that the slow full-length search happens only in the directed part.
  localparam int unsigned WIDE_TRIAL_CAP = 200;
  localparam int unsigned RANDOM_ITEMS = 100;
  localparam int unsigned DRAIN_CYCLES = 20;

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_stall;
  logic [VW-1:0] in_number;
  logic          out_valid;
  logic          out_stall;
  logic          out_is_prime;

  logic [VW-1:0] numbers_to_send[$];   // stimulus not yet presented
  bit            verdicts_due[$];      // expected is_prime, oldest first
  int unsigned   items_total;
  int unsigned   items_taken;
  int unsigned   mismatches;
  int unsigned   quiet_cycles;
  int unsigned   send_gap;
  int unsigned   hold_gap;
  int unsigned   mon_trials;
  logic          in_took;              // input transfer at the last rising edge
  logic          bursts_on;

  trial_division_prime_test #(
    .VALUE_WIDTH(VW)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_number   (in_number),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_is_prime(out_is_prime)
  );

  always #1 clk = ~clk;

  // Idling runs in bursts, except every third group of ten items and the
  // last quarter of the run, which go at full rate.
  assign bursts_on = (items_taken < items_total * 3 / 4) && ((items_taken / 10) % 3 != 2);

  // Primality of a signed value by trial division over odd divisors.
  // trials reports how many odd divisors were tried, used to bound stimulus cost.
  function automatic bit prime_verdict(input logic signed [VW-1:0] value,
                                       output int unsigned trials);
    longint unsigned n;
    longint unsigned d;
    trials = 0;
    if (value < SMALLEST_PRIME) return 1'b0;   // negatives, zero and one
    n = value;
    if (n == SMALLEST_PRIME) return 1'b1;
    if (n % 2 == 0) return 1'b0;
    // d <= n/d is the exact integer form of d*d <= n
    for (d = FIRST_DIVISOR; d <= n / d; d += 2) begin
      trials++;
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Input driver: changes only at the falling edge. A presented value holds
  // until its transfer is seen, then the next one (or a gap) follows.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_took)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (numbers_to_send.size() == 0) begin
        in_valid <= 1'b0;
      end else if (bursts_on && $urandom_range(0, 5) == 0) begin
        send_gap = $urandom_range(0, 8);
        in_valid <= 1'b0;
      end else begin
        in_valid  <= 1'b1;
        in_number <= numbers_to_send.pop_front();
      end
    end
  end

  // Result receiver: stalls in random bursts.
  always @(negedge clk) begin
    if (hold_gap > 0) begin
      hold_gap--;
      out_stall <= 1'b1;
    end else if (rst_n && bursts_on && $urandom_range(0, 7) == 0) begin
      hold_gap = $urandom_range(0, 8);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: samples both channels at the rising edge, before the block's
  // own updates land. Predicts on each input transfer, checks each result.
  always @(posedge clk) begin
    in_took <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        verdicts_due.push_back(prime_verdict(in_number, mon_trials));
        items_taken++;
      end
      if (out_valid && !out_stall) begin
        if (verdicts_due.size() == 0) begin
          $error("out_is_prime: expected none, actual %0b", out_is_prime);
          mismatches++;
        end else if (out_is_prime !== verdicts_due[0]) begin
          $error("out_is_prime: expected %0b, actual %0b", verdicts_due[0], out_is_prime);
          mismatches++;
          void'(verdicts_due.pop_front());
        end else begin
          void'(verdicts_due.pop_front());
        end
      end
      // watchdog on transfers, either side
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    logic [VW-1:0] pick;
    int unsigned   cost;
    int unsigned   kind;
    int unsigned   root;
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_number    = '0;
    out_stall    = 1'b0;
    in_took      = 1'b0;
    items_taken  = 0;
    mismatches   = 0;
    quiet_cycles = 0;
    send_gap     = 0;
    hold_gap     = 0;
    items_total  = 0;

    // Directed: zero, one, two, small primes and squares of primes (divisor
    // exactly at the bound), 16-bit edges, negatives, both field extremes, and
    // the largest positive value, which is prime and takes the full search.
    numbers_to_send = '{0, 1, 2, 3, 4, 5, 9, 15, 25, 49, 63001, 65521, 65535, 65537,
                        1000003, 1431655765, 2147483645, 2147483646, -1, -2, -7};
    numbers_to_send.push_back({1'b1, {(VW-1){1'b0}}});    // most negative
    numbers_to_send.push_back({(VW/2){2'b10}});           // alternating, negative
    numbers_to_send.push_back({1'b0, {(VW-1){1'b1}}});    // most positive

    // Random: mostly cheap values, with wide even, negative and wide odd
    // composites to toggle every bit of the field.
    repeat (RANDOM_ITEMS) begin
      kind = $urandom_range(0, 9);
      if (kind <= 3) begin
        pick = $urandom_range(0, $urandom_range(0, 1) ? 255 : 65535);
      end else if (kind <= 5) begin
        pick = $urandom;
        pick[VW-1] = 1'b1;
      end else if (kind == 6) begin
        pick = $urandom;
        pick[0] = 1'b0;
      end else if (kind <= 8) begin
        do begin
          pick = $urandom;
          pick[VW-1] = 1'b0;
          pick[0] = 1'b1;
          void'(prime_verdict(pick, cost));
        end while (cost > WIDE_TRIAL_CAP);
      end else begin
        root = 2 * $urandom_range(1, 127) + 1;
        pick = root * root;
      end
      numbers_to_send.push_back(pick);
    end
    items_total = numbers_to_send.size();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Drain: every item taken and every verdict returned, then a short tail
    // to catch any stray result.
    do @(negedge clk); while (items_taken < items_total || verdicts_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/tdpt_pkg.sv
design/tdpt_rem_step.sv
design/trial_division_prime_test.sv
sim/testbench.sv
